FILE: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the checker files.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
	else $error("assertion failed: lbl");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
	else $error("assertion failed: lbl");

`endif

FILE: rtl/ple_pkg.sv
// ---------------------------------------------------------------------------
// ple_pkg
// Shared codes and types of the positional list engine.
// ---------------------------------------------------------------------------
package ple_pkg;

	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_DELETE = 1'b1;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	localparam int VAL_W = 32;
	localparam int PLACE_W = 5;
	localparam int LEN_W = 5;

	// Cells grouped per first-level reduction register.
	localparam int GROUP = 16;

	// Shift command broadcast to every cell.
	typedef struct packed {
		logic ins;
		logic del;
	} cell_ctl_t;

endpackage

FILE: rtl/ple_in_if.sv
// ---------------------------------------------------------------------------
// ple_in_if
// Request channel: operation kind, place and value.
// ---------------------------------------------------------------------------
interface ple_in_if;
	logic                                valid;
	logic                                ready;
	logic                                kind;
	logic        [ple_pkg::PLACE_W-1:0]  place;
	logic signed [ple_pkg::VAL_W-1:0]    value;

	modport source (output valid, output kind, output place, output value, input ready);
	modport sink   (input valid, input kind, input place, input value, output ready);
endinterface

FILE: rtl/ple_out_if.sv
// ---------------------------------------------------------------------------
// ple_out_if
// Response channel: status, removed value and new length.
// ---------------------------------------------------------------------------
interface ple_out_if;
	logic                               valid;
	logic                               ready;
	logic        [1:0]                  status;
	logic signed [ple_pkg::VAL_W-1:0]   removed_value;
	logic        [ple_pkg::LEN_W-1:0]   length;

	modport source (output valid, output status, output removed_value, output length,
		input ready);
	modport sink   (input valid, input status, input removed_value, input length,
		output ready);
endinterface

FILE: rtl/ple_cell.sv
// ---------------------------------------------------------------------------
// ple_cell
// One list slot: shifts toward or away from the target slot on command.
// ---------------------------------------------------------------------------
module ple_cell #(
	parameter int IDX = 0,
	parameter int W = 5
) (
	input  logic                        clk,
	input  ple_pkg::cell_ctl_t          ctl,
	input  logic [W-1:0]                tgt,
	input  logic [ple_pkg::VAL_W-1:0]   ins_value,
	input  logic [ple_pkg::VAL_W-1:0]   from_lower,
	input  logic [ple_pkg::VAL_W-1:0]   from_upper,
	output logic [ple_pkg::VAL_W-1:0]   data,
	output logic [ple_pkg::VAL_W-1:0]   pick
);

	localparam logic [W-1:0] MY_IDX = W'(IDX);

	logic [ple_pkg::VAL_W-1:0] data_q;

	always_ff @(posedge clk) begin
		if (ctl.ins && (MY_IDX > tgt)) begin
			data_q <= from_lower;
		end else if (ctl.ins && (MY_IDX == tgt)) begin
			data_q <= ins_value;
		end else if (ctl.del && (MY_IDX >= tgt)) begin
			data_q <= from_upper;
		end
	end

	assign data = data_q;
	// Only the slot being deleted offers its value to the reduction.
	assign pick = (ctl.del && (MY_IDX == tgt)) ? data_q : '0;

endmodule

FILE: rtl/positional_list_engine.sv
// ---------------------------------------------------------------------------
// positional_list_engine
// Bounded ordered list of signed values with insert and delete by position.
// ---------------------------------------------------------------------------
// Usage:
//   in_ch carries one request per transaction: kind (insert or delete),
//   place (0-based index for insert, 1-based position for delete) and value.
//   out_ch returns exactly one response per request: status, the removed
//   value (zero unless a delete succeeded) and the length after the request.
//   The list lives in a row of CAPACITY cells. The cells at and above the
//   target shift in the cycle a successful request is accepted, so a new
//   request can be accepted every cycle while out_ch is not stalled.
//   The removed value is collected by a two-stage registered OR tree over
//   the cells, and out_ch.valid is registered in step with its second stage.
//   Throughput is one transaction per cycle while out_ch is ready. When the
//   receiver stalls, the response is held and one more request is absorbed
//   in the intermediate stage; in_ch.ready then drops until out_ch drains.
//   Reset empties the list (length zero) and clears both pipeline stages;
//   cell contents are not reset and are never read before being written.
// ---------------------------------------------------------------------------
module positional_list_engine #(
	parameter int CAPACITY = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	ple_in_if.sink     in_ch,
	ple_out_if.source  out_ch
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int W = (CW > ple_pkg::PLACE_W) ? CW : ple_pkg::PLACE_W;
	localparam int NG = (CAPACITY + ple_pkg::GROUP - 1) / ple_pkg::GROUP;
	localparam logic [W-1:0] CAP_W = W'(CAPACITY);

	logic [CW-1:0]              count_q;
	logic                       v_s1;
	logic [1:0]                 status_s1;
	logic [ple_pkg::LEN_W-1:0]  len_s1;
	logic [ple_pkg::VAL_W-1:0]  grp_s1 [NG];
	logic                       out_v_q;
	logic [1:0]                 status_q;
	logic [ple_pkg::VAL_W-1:0]  removed_q;
	logic [ple_pkg::LEN_W-1:0]  len_q;

	logic                       acc;
	logic                       out_en;
	logic [W-1:0]               place_w;
	logic [W-1:0]               count_w;
	logic [W-1:0]               tgt;
	logic                       ok_ins;
	logic                       ok_del;
	logic [1:0]                 status_d;
	logic [CW-1:0]              count_d;
	ple_pkg::cell_ctl_t         ctl;
	logic [ple_pkg::VAL_W-1:0]  cell_data [CAPACITY];
	logic [ple_pkg::VAL_W-1:0]  pick_pad  [NG*ple_pkg::GROUP];
	logic [ple_pkg::VAL_W-1:0]  grp_d     [NG];
	logic [ple_pkg::VAL_W-1:0]  removed_d;

	assign out_en = !out_v_q || out_ch.ready;
	assign in_ch.ready = !v_s1 || out_en;
	assign acc = in_ch.valid && in_ch.ready;

	assign place_w = W'(in_ch.place);
	assign count_w = W'(count_q);

	always_comb begin
		ok_ins = 1'b0;
		ok_del = 1'b0;
		status_d = ple_pkg::ST_OK;
		count_d = count_q;
		tgt = place_w;
		if (in_ch.kind == ple_pkg::KIND_INSERT) begin
			if (place_w > count_w) begin
				status_d = ple_pkg::ST_RANGE;
			end else if (count_w == CAP_W) begin
				status_d = ple_pkg::ST_FULL;
			end else begin
				ok_ins = 1'b1;
				count_d = count_q + 1'b1;
			end
		end else begin
			tgt = place_w - 1'b1;
			if ((in_ch.place == '0) || (place_w > count_w)) begin
				status_d = ple_pkg::ST_RANGE;
			end else begin
				ok_del = 1'b1;
				count_d = count_q - 1'b1;
			end
		end
	end

	assign ctl.ins = acc && ok_ins;
	assign ctl.del = acc && ok_del;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [ple_pkg::VAL_W-1:0] lower;
		logic [ple_pkg::VAL_W-1:0] upper;
		if (i == 0) begin : g_bot
			assign lower = '0;
		end else begin : g_low
			assign lower = cell_data[i-1];
		end
		if (i == CAPACITY - 1) begin : g_top
			assign upper = '0;
		end else begin : g_up
			assign upper = cell_data[i+1];
		end
		ple_cell #(.IDX(i), .W(W)) u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.tgt        (tgt),
			.ins_value  (in_ch.value),
			.from_lower (lower),
			.from_upper (upper),
			.data       (cell_data[i]),
			.pick       (pick_pad[i])
		);
	end

	for (genvar j = CAPACITY; j < NG * ple_pkg::GROUP; j++) begin : g_pad
		assign pick_pad[j] = '0;
	end

	always_comb begin
		for (int g = 0; g < NG; g++) begin
			grp_d[g] = '0;
			for (int k = 0; k < ple_pkg::GROUP; k++) begin
				grp_d[g] = grp_d[g] | pick_pad[g*ple_pkg::GROUP + k];
			end
		end
	end

	always_comb begin
		removed_d = '0;
		for (int g = 0; g < NG; g++) begin
			removed_d = removed_d | grp_s1[g];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			v_s1 <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (acc) begin
				count_q <= count_d;
			end
			if (acc) begin
				v_s1 <= 1'b1;
			end else if (out_en) begin
				v_s1 <= 1'b0;
			end
			if (out_en) begin
				out_v_q <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			status_s1 <= status_d;
			len_s1 <= ple_pkg::LEN_W'(count_d);
			grp_s1 <= grp_d;
		end
		if (out_en && v_s1) begin
			status_q <= status_s1;
			len_q <= len_s1;
			removed_q <= removed_d;
		end
	end

	assign out_ch.valid = out_v_q;
	assign out_ch.status = status_q;
	assign out_ch.removed_value = removed_q;
	assign out_ch.length = len_q;

endmodule

FILE: rtl/ple_checker.sv
// ---------------------------------------------------------------------------
// ple_checker
// Port-level checks of the positional list engine, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ple_checker #(
	parameter int CAPACITY = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        out_valid,
	input  logic                        out_ready,
	input  logic [1:0]                  status,
	input  logic [ple_pkg::VAL_W-1:0]   removed_value,
	input  logic [ple_pkg::LEN_W-1:0]   length
);

	localparam logic [ple_pkg::LEN_W-1:0] CAP_LEN = ple_pkg::LEN_W'(CAPACITY);

	// A stalled response keeps its contents.
	`ASSERT_NEXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(status) && $stable(removed_value) && $stable(length))

	// Only the three defined status codes are produced.
	`ASSERT_IMPL(a_code, clk, arst_n, out_valid, status == ple_pkg::ST_OK || status == ple_pkg::ST_RANGE || status == ple_pkg::ST_FULL)

	// A failed request never reports a removed value.
	`ASSERT_IMPL(a_zero, clk, arst_n, out_valid && status != ple_pkg::ST_OK, removed_value == '0)

	// A full list reports its capacity as the length.
	`ASSERT_IMPL(a_full, clk, arst_n, out_valid && status == ple_pkg::ST_FULL, length == CAP_LEN)

endmodule

bind positional_list_engine ple_checker #(.CAPACITY(CAPACITY)) u_ple_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_ch.valid),
	.out_ready     (out_ch.ready),
	.status        (out_ch.status),
	.removed_value (out_ch.removed_value),
	.length        (out_ch.length)
);
